### src/hhfr_pkg.sv
`default_nettype none
package hhfr_pkg;

    localparam int OffsetBits = 16;
    localparam int NameCount  = 10;
    localparam int AeIndex    = 5;
    localparam int FifoDepth  = 4;

    localparam logic [OffsetBits-1:0] OfsMax = {OffsetBits{1'b1}};
    localparam logic [NameCount-1:0]  NameAll = {NameCount{1'b1}};

    localparam logic [3:0] MaskIdent = 4'd1;
    localparam logic [3:0] MaskAll   = 4'd15;

    localparam logic [7:0] ChCr    = 8'h0D;
    localparam logic [7:0] ChLf    = 8'h0A;
    localparam logic [7:0] ChSp    = 8'h20;
    localparam logic [7:0] ChColon = 8'h3A;
    localparam logic [7:0] ChComma = 8'h2C;
    localparam logic [7:0] ChSemi  = 8'h3B;
    localparam logic [7:0] ChDash  = 8'h2D;
    localparam logic [7:0] ChStar  = 8'h2A;
    localparam logic [7:0] ChQ     = 8'h71;
    localparam logic [7:0] ChEq    = 8'h3D;
    localparam logic [7:0] ChPlus  = 8'h2B;
    localparam logic [7:0] ChDot   = 8'h2E;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChOne   = 8'h31;
    localparam logic [7:0] ChNine  = 8'h39;

    localparam logic [127:0] HdrNames [NameCount] = '{
        128'("referer"), 128'("user-agent"), 128'("cookie"), 128'("x-forwarded-for"),
        128'("host"), 128'("accept-encoding"), 128'("content-type"),
        128'("if-none-match"), 128'("accept-language"), 128'("origin")
    };
    localparam logic [4:0] HdrLens [NameCount] = '{
        5'd7, 5'd10, 5'd6, 5'd15, 5'd4, 5'd15, 5'd12, 5'd13, 5'd15, 5'd6
    };

    localparam logic [63:0] EncNames [4] = '{
        64'("*"), 64'("gzip"), 64'("compress"), 64'("deflate")
    };
    localparam logic [3:0] EncLens [4] = '{4'd1, 4'd4, 4'd8, 4'd7};
    localparam logic [3:0] EncBits [4] = '{MaskAll, 4'd2, 4'd4, 4'd8};

    typedef enum logic [2:0] {
        TP_VSTART, TP_TOKEN, TP_PARAM_SP, TP_PARAM_Q,
        TP_NUM, TP_IGNORE, TP_SEP_SP, TP_FIXED
    } tok_phase_t;

    typedef enum logic [3:0] {
        Q_COUNTS, Q_NOCOUNT, Q_LEAD, Q_INT,
        Q_FRAC1, Q_FRAC2, Q_FRAC3, Q_FRAC4, Q_EXACT
    } q_state_t;

    typedef struct packed {
        tok_phase_t phase;
        logic [3:0] cand;
        logic [3:0] idx;
        q_state_t   q;
        logic [3:0] wmask;
    } tok_t;

    typedef struct packed {
        logic        kind;
        logic [3:0]  id;
        logic [15:0] vstart;
        logic [15:0] vlen;
        logic [3:0]  mask;
        logic        ovf;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [2:0] level;
        logic       room2;
    } fifo_stat_t;

    function automatic logic [7:0] hdr_char(int k, logic [4:0] i);
        logic [127:0] w;
        w = HdrNames[k] >> (8 * (int'(HdrLens[k]) - 1 - int'(i[3:0])));
        return w[7:0];
    endfunction

    function automatic logic [7:0] enc_char(int k, logic [3:0] i);
        logic [63:0] w;
        w = EncNames[k] >> (8 * (int'(EncLens[k]) - 1 - int'(i[2:0])));
        return w[7:0];
    endfunction

    function automatic logic [NameCount-1:0] exact_names(logic [NameCount-1:0] cand,
                                                         logic [4:0] idx);
        logic [NameCount-1:0] m;
        for (int k = 0; k < NameCount; k++)
            m[k] = cand[k] && (HdrLens[k] == idx);
        return m;
    endfunction

    function automatic tok_t tok_end(tok_t t);
        tok_t r;
        r = t;
        if (t.q == Q_COUNTS)
            for (int k = 0; k < 4; k++)
                if (t.cand[k] && t.idx >= EncLens[k])
                    r.wmask = r.wmask | EncBits[k];
        r.cand = 4'hF;
        r.idx  = '0;
        r.q    = Q_COUNTS;
        return r;
    endfunction

    function automatic tok_t tok_byte(tok_t t, logic [7:0] b);
        tok_t r;
        r = t;
        if (b == ChComma) begin
            r = tok_end(t);
            r.phase = TP_SEP_SP;
        end else if (b == ChSemi) begin
            r.phase = TP_PARAM_SP;
        end else begin
            for (int k = 0; k < 4; k++)
                if (t.cand[k] && t.idx < EncLens[k] && b != enc_char(k, t.idx))
                    r.cand[k] = 1'b0;
            if (t.idx != 4'd15)
                r.idx = t.idx + 4'd1;
            r.phase = TP_TOKEN;
        end
        return r;
    endfunction

    function automatic q_state_t num_step(q_state_t s, logic [7:0] b);
        logic dig;
        q_state_t r;
        dig = (b >= ChZero) && (b <= ChNine);
        r = s;
        case (s)
            Q_LEAD:
            begin
                if (b == ChSp || (b >= 8'd9 && b <= 8'd13)) r = s;
                else if (b == ChPlus) r = Q_INT;
                else if (b == ChDot) r = Q_FRAC1;
                else if (dig) r = (b == ChZero) ? Q_INT : Q_COUNTS;
                else r = Q_NOCOUNT;
            end
            Q_INT:
            begin
                if (b == ChDot) r = Q_FRAC1;
                else if (dig) r = (b == ChZero) ? s : Q_COUNTS;
                else r = Q_NOCOUNT;
            end
            Q_FRAC1, Q_FRAC2, Q_FRAC3:
            begin
                if (b == ChZero) r = (s == Q_FRAC1) ? Q_FRAC2 :
                                     (s == Q_FRAC2) ? Q_FRAC3 : Q_FRAC4;
                else r = dig ? Q_COUNTS : Q_NOCOUNT;
            end
            Q_FRAC4:
            begin
                if (b == ChOne) r = Q_EXACT;
                else if (dig && b != ChZero) r = Q_COUNTS;
                else r = Q_NOCOUNT;
            end
            Q_EXACT:
            begin
                if (dig) r = (b == ChZero) ? s : Q_COUNTS;
                else r = Q_NOCOUNT;
            end
            default: r = s;
        endcase
        return r;
    endfunction

    function automatic tok_t dec_step(tok_t t, logic [7:0] b);
        tok_t r;
        r = t;
        case (t.phase)
            TP_FIXED: r = t;
            TP_VSTART:
            begin
                if (b == ChDash) begin
                    r.wmask = MaskIdent;
                    r.phase = TP_FIXED;
                end else if (b == ChStar) begin
                    r.wmask = MaskAll;
                    r.phase = TP_FIXED;
                end else begin
                    r = tok_byte(t, b);
                end
            end
            TP_SEP_SP:
            begin
                if (b != ChSp) r = tok_byte(t, b);
            end
            TP_TOKEN: r = tok_byte(t, b);
            TP_PARAM_SP:
            begin
                if (b == ChComma) begin
                    r = tok_end(t);
                    r.phase = TP_SEP_SP;
                end else if (b == ChQ) r.phase = TP_PARAM_Q;
                else if (b != ChSp) r.phase = TP_IGNORE;
            end
            TP_PARAM_Q:
            begin
                if (b == ChComma) begin
                    r = tok_end(t);
                    r.phase = TP_SEP_SP;
                end else if (b == ChEq) begin
                    r.phase = TP_NUM;
                    r.q = Q_LEAD;
                end else r.phase = TP_IGNORE;
            end
            TP_NUM:
            begin
                if (b == ChComma) begin
                    r = tok_end(t);
                    r.phase = TP_SEP_SP;
                end else r.q = num_step(t.q, b);
            end
            default:
            begin
                if (b == ChComma) begin
                    r = tok_end(t);
                    r.phase = TP_SEP_SP;
                end
            end
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

### src/hhfr_res_fifo.sv
`default_nettype none
module hhfr_res_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_a,
    input  wire hhfr_pkg::res_t data_a,
    input  wire logic          push_b,
    input  wire hhfr_pkg::res_t data_b,
    input  wire logic          pop,
    output hhfr_pkg::res_t     head,
    output logic               not_empty,
    output hhfr_pkg::fifo_stat_t stat
);
    import hhfr_pkg::*;

    res_t       mem_reg [FifoDepth];
    logic [1:0] wr_reg, wr_next;
    logic [1:0] rd_reg, rd_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       do_pop;

    always_comb
    begin
        do_pop   = pop && (cnt_reg != 3'd0);
        wr_next  = wr_reg + {1'b0, push_a} + {1'b0, push_b};
        rd_next  = rd_reg + {1'b0, do_pop};
        cnt_next = cnt_reg + {2'b0, push_a} + {2'b0, push_b} - {2'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_a)
            mem_reg[wr_reg] <= data_a;
        if (push_b)
            mem_reg[wr_reg + 2'd1] <= data_b;
    end

    assign head        = mem_reg[rd_reg];
    assign not_empty   = (cnt_reg != 3'd0);
    assign stat.level  = cnt_reg;
    assign stat.room2  = (cnt_reg <= 3'd2);

endmodule
`default_nettype wire

### src/http_header_field_recognizer_core.sv
// HTTP header field recognizer.
// Input channel (in_valid/in_ready): one header byte per word, end_of_block on
// the final byte of a block. Output channel (out_valid/out_ready): one result
// word each: a line result for every recognized header line, and a summary
// with the accept-encoding mask after the final byte.
// A byte is held in an input register; the line parser runs on it
// combinationally and pushes zero, one or two results into a four-entry
// result queue whose head drives the output ports. A result reaches the
// output after its byte has passed the input register and the result queue.
// Throughput is one byte per cycle while the queue holds at most two results;
// a byte that yields two results is drained as two output words.
// When the receiver stalls, the queue fills and in_ready drops once the queue
// cannot take two more results and the input register is occupied.
// Reset clears the parser state, offsets and the queue; after a summary the
// parser returns to its reset state for the next block.
`default_nettype none
module http_header_field_recognizer_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        end_of_block,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             result_kind,
    output logic [3:0]       header_id,
    output logic [15:0]      value_start,
    output logic [15:0]      value_length,
    output logic [3:0]       encoding_mask,
    output logic             offset_overflow,
    output logic             last_result
);
    import hhfr_pkg::*;

    logic                  iv_reg;
    logic [7:0]            ib_reg;
    logic                  ie_reg;

    logic [OffsetBits-1:0] pos_reg, pos_next;
    logic                  inval_reg, inval_next;
    logic [4:0]            nidx_reg, nidx_next;
    logic [NameCount-1:0]  ncand_reg, ncand_next;
    logic [OffsetBits-1:0] lvs_reg, lvs_next;
    logic [1:0]            ale_reg, ale_next;
    tok_t                  tok_reg, tok_next;
    logic [3:0]            cmask_reg, cmask_next;
    logic                  ovf_reg, ovf_next;

    fifo_stat_t            fstat;
    res_t                  head;
    logic                  fire;
    logic                  push_a, push_b;
    res_t                  res_a, res_b, line_res, sum_res;

    // per-byte working values
    logic                  m_inval;
    logic [4:0]            m_nidx;
    logic [NameCount-1:0]  m_ncand;
    logic [OffsetBits-1:0] m_lvs;
    tok_t                  m_tok;
    logic                  is_cr;
    logic                  fin;
    logic [OffsetBits-1:0] fin_end, fin_vs;
    logic [NameCount-1:0]  fin_cand;
    logic [3:0]            fin_id;
    logic                  fin_hit;
    logic [3:0]            cmask_mid;
    logic [7:0]            lb;
    tok_t                  tok_fin;

    assign fire     = iv_reg && fstat.room2;
    assign in_ready = !iv_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            iv_reg <= 1'b0;
        else if (in_ready)
            iv_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            ib_reg <= in_byte;
            ie_reg <= end_of_block;
        end
    end

    always_comb
    begin
        pos_next   = pos_reg;
        ovf_next   = ovf_reg;
        ale_next   = 2'd0;
        m_inval    = inval_reg;
        m_nidx     = nidx_reg;
        m_ncand    = ncand_reg;
        m_lvs      = lvs_reg;
        m_tok      = tok_reg;
        is_cr      = 1'b0;
        lb         = ib_reg;
        fin_id     = '0;
        fin_hit    = 1'b0;
        cmask_mid  = cmask_reg;

        if (pos_reg == OfsMax)
            ovf_next = 1'b1;
        else
            pos_next = pos_reg + 1'b1;

        if (ale_reg == 2'd1 && ib_reg == ChLf)
        begin
            m_inval = inval_reg;
        end
        else if (ale_reg == 2'd2 && ib_reg == ChSp)
        begin
            m_lvs = pos_next;
        end
        else if (ib_reg == ChCr)
        begin
            is_cr    = 1'b1;
            ale_next = 2'd1;
        end
        else if (!inval_reg)
        begin
            if (ib_reg == ChColon)
            begin
                m_ncand  = exact_names(ncand_reg, nidx_reg);
                m_inval  = 1'b1;
                m_lvs    = pos_next;
                ale_next = 2'd2;
            end
            else
            begin
                if (ib_reg >= 8'h41 && ib_reg <= 8'h5A)
                    lb = ib_reg + 8'd32;
                for (int k = 0; k < NameCount; k++)
                    if (ncand_reg[k] &&
                        (nidx_reg >= HdrLens[k] || lb != hdr_char(k, nidx_reg)))
                        m_ncand[k] = 1'b0;
                if (nidx_reg != 5'd31)
                    m_nidx = nidx_reg + 5'd1;
            end
        end
        else
        begin
            m_tok = dec_step(tok_reg, ib_reg);
        end

        // line finish: at CR with end = pos, or at block end with end = next
        fin     = is_cr || (ie_reg && (m_inval || m_nidx != 5'd0));
        fin_end = is_cr ? pos_reg : pos_next;
        if (m_inval)
        begin
            fin_cand = m_ncand;
            fin_vs   = m_lvs;
        end
        else
        begin
            fin_cand = exact_names(m_ncand, m_nidx);
            fin_vs   = fin_end;
        end
        for (int k = NameCount - 1; k >= 0; k--)
            if (fin_cand[k])
            begin
                fin_hit = 1'b1;
                fin_id  = 4'(k);
            end
        tok_fin = tok_end(m_tok);
        if (fin && fin_hit && fin_id == 4'(AeIndex))
        begin
            if (!m_inval)
                cmask_mid = MaskIdent;
            else if (m_tok.phase != TP_FIXED)
                cmask_mid = tok_fin.wmask;
            else
                cmask_mid = m_tok.wmask;
        end

        line_res.kind   = 1'b0;
        line_res.id     = fin_id + 4'd1;
        line_res.vstart = 16'(fin_vs);
        line_res.vlen   = 16'(fin_end - fin_vs);
        line_res.mask   = '0;
        line_res.ovf    = ovf_next;
        line_res.last   = !ie_reg;

        sum_res.kind    = 1'b1;
        sum_res.id      = '0;
        sum_res.vstart  = '0;
        sum_res.vlen    = '0;
        sum_res.mask    = cmask_mid;
        sum_res.ovf     = ovf_next;
        sum_res.last    = 1'b1;

        push_a = fire && ((fin && fin_hit) || ie_reg);
        push_b = fire && fin && fin_hit && ie_reg;
        res_a  = (fin && fin_hit) ? line_res : sum_res;
        res_b  = sum_res;

        inval_next = m_inval;
        nidx_next  = m_nidx;
        ncand_next = m_ncand;
        lvs_next   = m_lvs;
        tok_next   = m_tok;
        cmask_next = cmask_mid;
        if (fin)
        begin
            inval_next        = 1'b0;
            nidx_next         = '0;
            ncand_next        = NameAll;
            lvs_next          = '0;
            tok_next.phase    = TP_VSTART;
            tok_next.cand     = 4'hF;
            tok_next.idx      = '0;
            tok_next.q        = Q_COUNTS;
            tok_next.wmask    = MaskIdent;
        end
        if (ie_reg)
        begin
            pos_next       = '0;
            ovf_next       = 1'b0;
            ale_next       = 2'd0;
            cmask_next     = MaskIdent;
            inval_next     = 1'b0;
            nidx_next      = '0;
            ncand_next     = NameAll;
            lvs_next       = '0;
            tok_next.phase = TP_VSTART;
            tok_next.cand  = 4'hF;
            tok_next.idx   = '0;
            tok_next.q     = Q_COUNTS;
            tok_next.wmask = MaskIdent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            inval_reg <= 1'b0;
            nidx_reg  <= '0;
            ncand_reg <= NameAll;
            lvs_reg   <= '0;
            ale_reg   <= '0;
            tok_reg   <= '{phase: TP_VSTART, cand: 4'hF, idx: 4'd0, q: Q_COUNTS,
                           wmask: MaskIdent};
            cmask_reg <= MaskIdent;
            ovf_reg   <= 1'b0;
        end
        else if (fire)
        begin
            pos_reg   <= pos_next;
            inval_reg <= inval_next;
            nidx_reg  <= nidx_next;
            ncand_reg <= ncand_next;
            lvs_reg   <= lvs_next;
            ale_reg   <= ale_next;
            tok_reg   <= tok_next;
            cmask_reg <= cmask_next;
            ovf_reg   <= ovf_next;
        end
    end

    hhfr_res_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_a    (push_a),
        .data_a    (res_a),
        .push_b    (push_b),
        .data_b    (res_b),
        .pop       (out_ready),
        .head      (head),
        .not_empty (out_valid),
        .stat      (fstat)
    );

    assign result_kind     = head.kind;
    assign header_id       = head.id;
    assign value_start     = head.vstart;
    assign value_length    = head.vlen;
    assign encoding_mask   = head.mask;
    assign offset_overflow = head.ovf;
    assign last_result     = head.last;

    a_eob_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && ie_reg |=> pos_reg == '0 && !ovf_reg && !inval_reg)
        else $error("state not cleared after block end");

    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fstat.level <= 3'(FifoDepth))
        else $error("result queue overflow");

    a_eob_summary: assert property (@(posedge clk) disable iff (!rst_n)
        fire && ie_reg |-> push_a)
        else $error("block end without summary");

endmodule
`default_nettype wire
